// File: src/ffc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared constants, types and helper functions of the fuzzy fall classifier.
// ----------------------------------------------------------------------------
package ffc_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int GRADE_W         = FRAC_BITS + 1;
	localparam int SMP_W           = 16;
	localparam int EDGE_W          = SMP_W + 1;
	localparam int DIFF_W          = SMP_W;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = (FRAC_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int DIV_STEPS       = DIV_STAGES * STEPS_PER_STAGE;
	localparam int QUOT_W          = DIV_STEPS + 1;
	localparam int QUOT_SHIFT      = DIV_STEPS - FRAC_BITS;
	localparam int PROD_W          = 2 * GRADE_W;
	localparam int RULES           = 9;
	localparam int SETS            = 3;
	localparam int LANES           = 2 * SETS;
	localparam int RULE_W          = 4;
	localparam int CLASS_W         = 2;
	localparam int CLASS_TBL_W     = RULES * CLASS_W;
	localparam int STRENGTH_W      = 17;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 48;
	localparam int PIPE_STAGES     = DIV_STAGES + 4;

	localparam logic [CLASS_TBL_W-1:0] CLASS_TBL_RST = 18'd152832;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_LOW  = 3'd0,
		REG_ACCEL_MID  = 3'd1,
		REG_ACCEL_HIGH = 3'd2,
		REG_SOUND_LOW  = 3'd3,
		REG_SOUND_MID  = 3'd4,
		REG_SOUND_HIGH = 3'd5,
		REG_CLASS_TBL  = 3'd6
	} cfg_reg_t;

	// One membership grade on its way through the divider.
	typedef struct packed {
		logic              sl;
		logic              one;
		logic [DIFF_W-1:0] rem;
		logic [DIFF_W-1:0] den;
		logic [QUOT_W-1:0] q;
	} lane_t;

	typedef struct packed {
		logic prod;
		logic grp;
		logic res;
	} pick_en_t;

	function automatic lane_t lane_const(input logic one);
		lane_t l;
		l     = '0;
		l.one = one;
		return l;
	endfunction

	function automatic lane_t lane_slope(input logic [DIFF_W-1:0] num,
		input logic [DIFF_W-1:0] den);
		lane_t l;
		l     = '0;
		l.sl  = 1'b1;
		l.den = den;
		if (num == den) begin
			l.q   = QUOT_W'(1);
			l.rem = '0;
		end else begin
			l.rem = num;
		end
		return l;
	endfunction

	function automatic lane_t lane_step(input lane_t li);
		lane_t         l;
		logic [DIFF_W:0] t;
		l = li;
		t = {l.rem, 1'b0};
		if (t >= {1'b0, l.den}) begin
			t     = t - {1'b0, l.den};
			l.rem = t[DIFF_W-1:0];
			l.q   = {l.q[QUOT_W-2:0], 1'b1};
		end else begin
			l.rem = t[DIFF_W-1:0];
			l.q   = {l.q[QUOT_W-2:0], 1'b0};
		end
		return l;
	endfunction

	function automatic logic [GRADE_W-1:0] lane_grade(input lane_t l);
		logic [GRADE_W-1:0] g;
		if (l.sl) begin
			g = l.q[QUOT_SHIFT +: GRADE_W];
		end else if (l.one) begin
			g = {1'b1, {FRAC_BITS{1'b0}}};
		end else begin
			g = '0;
		end
		return g;
	endfunction

endpackage
`default_nettype wire

// File: src/fuzzy_fall_classifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_fall_classifier_top
// Fuzzy fall classifier: fuzzifies an acceleration sample and a sound level,
// forms nine product rules and reports the strongest rule and its class.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_stall     accel_sample, sound_level
//   out      out_valid / out_stall   fall_class, winning_rule, rule_strength
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word enters per cycle unless a stalled output has filled the
// pipeline; the restoring dividers resolve four quotient bits per
// stage. Each stage advances when it is empty or its successor
// advances, so bubbles collapse and a stalled output word holds steady.
// Reset clears the valid bits and restores the configuration registers.
// ----------------------------------------------------------------------------
module fuzzy_fall_classifier_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [ffc_pkg::SMP_W-1:0]      accel_sample,
	input  wire logic [ffc_pkg::SMP_W-1:0]             sound_level,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [ffc_pkg::CLASS_W-1:0]                fall_class,
	output logic [ffc_pkg::RULE_W-1:0]                 winning_rule,
	output logic [ffc_pkg::STRENGTH_W-1:0]             rule_strength,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [ffc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [ffc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int ES = ffc_pkg::SMP_W;

	logic [2*ES-1:0]                   accel_low_q, accel_high_q;
	logic [3*ES-1:0]                   accel_mid_q;
	logic [2*ES-1:0]                   sound_low_q, sound_high_q;
	logic [3*ES-1:0]                   sound_mid_q;
	logic [ffc_pkg::CLASS_TBL_W-1:0]   class_tbl_q;

	logic [ffc_pkg::PIPE_STAGES-1:0]   vld_q;
	logic [ffc_pkg::PIPE_STAGES:0]     rdy;
	ffc_pkg::lane_t [ffc_pkg::LANES-1:0] div_lane [ffc_pkg::DIV_STAGES+1];
	ffc_pkg::pick_en_t                 pick_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_low_q  <= '0;
			accel_mid_q  <= '0;
			accel_high_q <= '0;
			sound_low_q  <= '0;
			sound_mid_q  <= '0;
			sound_high_q <= '0;
			class_tbl_q  <= ffc_pkg::CLASS_TBL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ffc_pkg::REG_ACCEL_LOW:  accel_low_q  <= cfg_data[2*ES-1:0];
				ffc_pkg::REG_ACCEL_MID:  accel_mid_q  <= cfg_data[3*ES-1:0];
				ffc_pkg::REG_ACCEL_HIGH: accel_high_q <= cfg_data[2*ES-1:0];
				ffc_pkg::REG_SOUND_LOW:  sound_low_q  <= cfg_data[2*ES-1:0];
				ffc_pkg::REG_SOUND_MID:  sound_mid_q  <= cfg_data[3*ES-1:0];
				ffc_pkg::REG_SOUND_HIGH: sound_high_q <= cfg_data[2*ES-1:0];
				ffc_pkg::REG_CLASS_TBL:
					class_tbl_q <= cfg_data[ffc_pkg::CLASS_TBL_W-1:0];
				default: ;
			endcase
		end
	end

	// Ready chain: a stage may load when it is empty or its word moves on.
	always_comb begin
		rdy[ffc_pkg::PIPE_STAGES] = !out_stall;
		for (int k = ffc_pkg::PIPE_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[ffc_pkg::PIPE_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < ffc_pkg::PIPE_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	ffc_fuzz u_fuzz_accel (
		.clk     (clk),
		.en      (rdy[0]),
		.x       ({accel_sample[ES-1], accel_sample}),
		.lo0     ({accel_low_q[ES-1], accel_low_q[ES-1:0]}),
		.lo1     ({accel_low_q[2*ES-1], accel_low_q[2*ES-1:ES]}),
		.mid0    ({accel_mid_q[ES-1], accel_mid_q[ES-1:0]}),
		.mid1    ({accel_mid_q[2*ES-1], accel_mid_q[2*ES-1:ES]}),
		.mid2    ({accel_mid_q[3*ES-1], accel_mid_q[3*ES-1:2*ES]}),
		.hi0     ({accel_high_q[ES-1], accel_high_q[ES-1:0]}),
		.hi1     ({accel_high_q[2*ES-1], accel_high_q[2*ES-1:ES]}),
		.lane_s1 (div_lane[0][ffc_pkg::SETS-1:0])
	);

	ffc_fuzz u_fuzz_sound (
		.clk     (clk),
		.en      (rdy[0]),
		.x       ({1'b0, sound_level}),
		.lo0     ({1'b0, sound_low_q[ES-1:0]}),
		.lo1     ({1'b0, sound_low_q[2*ES-1:ES]}),
		.mid0    ({1'b0, sound_mid_q[ES-1:0]}),
		.mid1    ({1'b0, sound_mid_q[2*ES-1:ES]}),
		.mid2    ({1'b0, sound_mid_q[3*ES-1:2*ES]}),
		.hi0     ({1'b0, sound_high_q[ES-1:0]}),
		.hi1     ({1'b0, sound_high_q[2*ES-1:ES]}),
		.lane_s1 (div_lane[0][ffc_pkg::LANES-1:ffc_pkg::SETS])
	);

	for (genvar k = 0; k < ffc_pkg::DIV_STAGES; k++) begin : g_div
		ffc_div u_div (
			.clk    (clk),
			.en     (rdy[k+1]),
			.lane_i (div_lane[k]),
			.lane_q (div_lane[k+1])
		);
	end

	assign pick_en.prod = rdy[ffc_pkg::DIV_STAGES+1];
	assign pick_en.grp  = rdy[ffc_pkg::DIV_STAGES+2];
	assign pick_en.res  = rdy[ffc_pkg::DIV_STAGES+3];

	ffc_pick u_pick (
		.clk           (clk),
		.en            (pick_en),
		.lane_i        (div_lane[ffc_pkg::DIV_STAGES]),
		.class_tbl     (class_tbl_q),
		.fall_class_s8 (fall_class),
		.rule_s8       (winning_rule),
		.strength_s8   (rule_strength)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_q[0] && out_stall))
		else $error("input stalled while pipeline can move");

	a_rule_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (winning_rule < ffc_pkg::RULE_W'(ffc_pkg::RULES)))
		else $error("winning rule out of range");

	a_strength_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rule_strength <= ffc_pkg::STRENGTH_W'(1 << ffc_pkg::FRAC_BITS)))
		else $error("rule strength above one");

	a_class_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fall_class ==
			class_tbl_q[winning_rule * ffc_pkg::CLASS_W +: ffc_pkg::CLASS_W]))
		else $error("class does not match table entry");

endmodule
`default_nettype wire

// File: src/ffc_fuzz.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffc_fuzz
// Segment selection for one input: sets up the low, medium and high grades.
// ----------------------------------------------------------------------------
module ffc_fuzz (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [ffc_pkg::EDGE_W-1:0]   x,
	input  wire logic signed [ffc_pkg::EDGE_W-1:0]   lo0,
	input  wire logic signed [ffc_pkg::EDGE_W-1:0]   lo1,
	input  wire logic signed [ffc_pkg::EDGE_W-1:0]   mid0,
	input  wire logic signed [ffc_pkg::EDGE_W-1:0]   mid1,
	input  wire logic signed [ffc_pkg::EDGE_W-1:0]   mid2,
	input  wire logic signed [ffc_pkg::EDGE_W-1:0]   hi0,
	input  wire logic signed [ffc_pkg::EDGE_W-1:0]   hi1,
	output ffc_pkg::lane_t [ffc_pkg::SETS-1:0]       lane_s1
);

	ffc_pkg::lane_t [ffc_pkg::SETS-1:0] lane_d;

	function automatic logic [ffc_pkg::DIFF_W-1:0] dif(
		input logic signed [ffc_pkg::EDGE_W-1:0] a,
		input logic signed [ffc_pkg::EDGE_W-1:0] b);
		logic signed [ffc_pkg::EDGE_W:0] s;
		s = $signed({a[ffc_pkg::EDGE_W-1], a}) - $signed({b[ffc_pkg::EDGE_W-1], b});
		return s[ffc_pkg::DIFF_W-1:0];
	endfunction

	always_comb begin
		if (x <= lo0) begin
			lane_d[0] = ffc_pkg::lane_const(1'b1);
		end else if (x <= lo1) begin
			lane_d[0] = ffc_pkg::lane_slope(dif(lo1, x), dif(lo1, lo0));
		end else begin
			lane_d[0] = ffc_pkg::lane_const(1'b0);
		end

		if (x <= mid0) begin
			lane_d[1] = ffc_pkg::lane_const(1'b0);
		end else if (x <= mid1) begin
			lane_d[1] = ffc_pkg::lane_slope(dif(x, mid0), dif(mid1, mid0));
		end else if (x <= mid2) begin
			lane_d[1] = ffc_pkg::lane_slope(dif(mid2, x), dif(mid2, mid1));
		end else begin
			lane_d[1] = ffc_pkg::lane_const(1'b0);
		end

		if (x <= hi0) begin
			lane_d[2] = ffc_pkg::lane_const(1'b0);
		end else if (x <= hi1) begin
			lane_d[2] = ffc_pkg::lane_slope(dif(x, hi0), dif(hi1, hi0));
		end else begin
			lane_d[2] = ffc_pkg::lane_const(1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane_d;
		end
	end

endmodule
`default_nettype wire

// File: src/ffc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffc_div
// One stage of the restoring dividers: four quotient bits for every grade.
// ----------------------------------------------------------------------------
module ffc_div (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire ffc_pkg::lane_t [ffc_pkg::LANES-1:0] lane_i,
	output ffc_pkg::lane_t [ffc_pkg::LANES-1:0]     lane_q
);

	ffc_pkg::lane_t [ffc_pkg::LANES-1:0] lane_d;

	always_comb begin
		for (int i = 0; i < ffc_pkg::LANES; i++) begin
			lane_d[i] = lane_i[i];
			for (int j = 0; j < ffc_pkg::STEPS_PER_STAGE; j++) begin
				lane_d[i] = ffc_pkg::lane_step(lane_d[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
		end
	end

endmodule
`default_nettype wire

// File: src/ffc_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffc_pick
// Rule products, first-maximum search in two levels and class lookup.
// ----------------------------------------------------------------------------
module ffc_pick (
	input  wire logic                                  clk,
	input  wire ffc_pkg::pick_en_t                     en,
	input  wire ffc_pkg::lane_t [ffc_pkg::LANES-1:0]   lane_i,
	input  wire logic [ffc_pkg::CLASS_TBL_W-1:0]       class_tbl,
	output logic [ffc_pkg::CLASS_W-1:0]                fall_class_s8,
	output logic [ffc_pkg::RULE_W-1:0]                 rule_s8,
	output logic [ffc_pkg::STRENGTH_W-1:0]             strength_s8
);

	logic [ffc_pkg::PROD_W-1:0] prod_s6 [ffc_pkg::RULES];
	logic [ffc_pkg::PROD_W-1:0] grp_best_s7 [ffc_pkg::SETS];
	logic [ffc_pkg::RULE_W-1:0] grp_rule_s7 [ffc_pkg::SETS];
	logic [ffc_pkg::PROD_W-1:0] grp_best_d [ffc_pkg::SETS];
	logic [ffc_pkg::RULE_W-1:0] grp_rule_d [ffc_pkg::SETS];
	logic [ffc_pkg::PROD_W-1:0] fin_best;
	logic [ffc_pkg::RULE_W-1:0] fin_rule;

	for (genvar r = 0; r < ffc_pkg::RULES; r++) begin : g_prod
		always_ff @(posedge clk) begin
			if (en.prod) begin
				prod_s6[r] <= ffc_pkg::PROD_W'(
					ffc_pkg::lane_grade(lane_i[r / ffc_pkg::SETS]) *
					ffc_pkg::lane_grade(lane_i[ffc_pkg::SETS + (r % ffc_pkg::SETS)]));
			end
		end
	end

	always_comb begin
		for (int g = 0; g < ffc_pkg::SETS; g++) begin
			grp_best_d[g] = prod_s6[g * ffc_pkg::SETS];
			grp_rule_d[g] = ffc_pkg::RULE_W'(g * ffc_pkg::SETS);
			for (int k = 1; k < ffc_pkg::SETS; k++) begin
				if (prod_s6[g * ffc_pkg::SETS + k] > grp_best_d[g]) begin
					grp_best_d[g] = prod_s6[g * ffc_pkg::SETS + k];
					grp_rule_d[g] = ffc_pkg::RULE_W'(g * ffc_pkg::SETS + k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.grp) begin
			grp_best_s7 <= grp_best_d;
			grp_rule_s7 <= grp_rule_d;
		end
	end

	always_comb begin
		fin_best = grp_best_s7[0];
		fin_rule = grp_rule_s7[0];
		for (int g = 1; g < ffc_pkg::SETS; g++) begin
			if (grp_best_s7[g] > fin_best) begin
				fin_best = grp_best_s7[g];
				fin_rule = grp_rule_s7[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.res) begin
			fall_class_s8 <= class_tbl[fin_rule * ffc_pkg::CLASS_W +: ffc_pkg::CLASS_W];
			rule_s8       <= fin_rule;
			strength_s8   <= fin_best[ffc_pkg::FRAC_BITS +: ffc_pkg::STRENGTH_W];
		end
	end

endmodule
`default_nettype wire
